FILE: src/m3inv_pkg.sv
// shared widths, types and the divider step for the 3x3 inverse pipeline
package m3inv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int A_W       = 16;
  localparam int PROD_W    = 2 * A_W;
  localparam int CO_W      = PROD_W + 1;
  localparam int DET_W     = CO_W + A_W + 2;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int OUT_W     = 48;
  localparam int N_ENT     = 9;

  // one divider stage: partial remainders, numerator/quotient shift words
  typedef struct packed {
    logic [N_ENT-1:0][DET_W-1:0] rem;
    logic [N_ENT-1:0][NUM_W-1:0] nq;
    logic [N_ENT-1:0]            neg;
    logic [DET_W-1:0]            dmag;
    logic                        sing;
  } div_stage_t;

  // one restoring step on every lane: next quotient bit enters at the bottom
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t    n;
    logic [DET_W:0] t;
    n = s;
    for (int k = 0; k < N_ENT; k++) begin
      t = {s.rem[k], s.nq[k][NUM_W-1]};
      if (t >= {1'b0, s.dmag}) begin
        n.rem[k] = DET_W'(t - {1'b0, s.dmag});
        n.nq[k]  = {s.nq[k][NUM_W-2:0], 1'b1};
      end else begin
        n.rem[k] = t[DET_W-1:0];
        n.nq[k]  = {s.nq[k][NUM_W-2:0], 1'b0};
      end
    end
    return n;
  endfunction

endpackage

FILE: src/matrix3x3_inverse_unit.sv
// 3x3 matrix inverse: adjugate over determinant, fully pipelined
//
//  channel | ports              | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_tvalid/tready   | tdata: a00..a22, 16 bits each, a00 lowest
//  out     | out_tvalid/tready  | tdata: inv00..inv22, 48 bits each;
//          |                    | tuser: singular
//
// one request per cycle unless out stalls; 4 stages of products, cofactors
// and determinant, 48 one-bit restoring divider stages, one output register.
// synchronous active-low reset clears the valid bits only.
// a stalled output freezes the whole pipeline; nothing is lost or repeated.
module matrix3x3_inverse_unit
  import m3inv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [N_ENT*A_W-1:0]     in_tdata,   // a00,a01,a02,a10,..,a22 from bit 0
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [N_ENT*OUT_W-1:0]   out_tdata,  // inv00,inv01,..,inv22 from bit 0
  output logic                     out_tuser   // singular
);

  logic en;

  logic signed [A_W-1:0]    a_r [N_ENT];
  logic signed [PROD_W-1:0] p_r [2*N_ENT];
  logic                     v1_r;
  logic signed [A_W-1:0]    a0_r [3];
  logic signed [CO_W-1:0]   c_r [N_ENT];
  logic                     v2_r;
  logic signed [DET_W-1:0]  dp_r [3];
  logic signed [CO_W-1:0]   c3_r [N_ENT];
  logic                     v3_r;
  div_stage_t               dv_r [NUM_W+1];
  logic [NUM_W:0]           dv_v_r;
  logic [N_ENT*OUT_W-1:0]   out_data_r;
  logic                     out_sing_r;
  logic                     out_valid_r;

  logic signed [A_W-1:0]    ai [N_ENT];
  logic signed [DET_W-1:0]  det;
  logic [DET_W-1:0]         dmag;
  div_stage_t               d0;
  div_stage_t               dl;
  logic [N_ENT*OUT_W-1:0]   res;
  logic [CO_W-1:0]          cm;
  logic [OUT_W-1:0]         q;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sing_r;

  always_comb begin
    for (int k = 0; k < N_ENT; k++) ai[k] = in_tdata[k*A_W +: A_W];
  end

  // stage 4 setup: determinant, sign split, transposed lane order
  always_comb begin
    det  = dp_r[0] + dp_r[1] + dp_r[2];
    dmag = det[DET_W-1] ? DET_W'(-det) : det;
    d0   = '0;
    d0.dmag = dmag;
    d0.sing = (det == '0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cm = c3_r[j*3+i][CO_W-1] ? CO_W'(-c3_r[j*3+i]) : CO_W'(c3_r[j*3+i]);
        d0.nq[i*3+j]  = NUM_W'(cm[PROD_W-1:0]) << FRAC_BITS;
        d0.neg[i*3+j] = c3_r[j*3+i][CO_W-1] ^ det[DET_W-1];
      end
    end
  end

  always_comb begin
    dl = dv_r[NUM_W];
    for (int k = 0; k < N_ENT; k++) begin
      q = OUT_W'(dl.nq[k]);
      if (dl.sing) q = '0;
      else if (dl.neg[k]) q = -q;
      res[k*OUT_W +: OUT_W] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      dv_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      dv_v_r      <= {dv_v_r[NUM_W-1:0], v3_r};
      out_valid_r <= dv_v_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: the eighteen 2x2 products
      p_r[0]  <= ai[4] * ai[8];  p_r[1]  <= ai[5] * ai[7];
      p_r[2]  <= ai[5] * ai[6];  p_r[3]  <= ai[3] * ai[8];
      p_r[4]  <= ai[3] * ai[7];  p_r[5]  <= ai[4] * ai[6];
      p_r[6]  <= ai[2] * ai[7];  p_r[7]  <= ai[1] * ai[8];
      p_r[8]  <= ai[0] * ai[8];  p_r[9]  <= ai[2] * ai[6];
      p_r[10] <= ai[1] * ai[6];  p_r[11] <= ai[0] * ai[7];
      p_r[12] <= ai[1] * ai[5];  p_r[13] <= ai[2] * ai[4];
      p_r[14] <= ai[2] * ai[3];  p_r[15] <= ai[0] * ai[5];
      p_r[16] <= ai[0] * ai[4];  p_r[17] <= ai[1] * ai[3];
      for (int k = 0; k < N_ENT; k++) a_r[k] <= ai[k];
      // stage 2: signed cofactors
      for (int k = 0; k < N_ENT; k++) c_r[k] <= CO_W'(p_r[2*k]) - CO_W'(p_r[2*k+1]);
      for (int k = 0; k < 3; k++) a0_r[k] <= a_r[k];
      // stage 3: expansion along row 0
      for (int k = 0; k < 3; k++) dp_r[k] <= DET_W'(a0_r[k]) * DET_W'(c_r[k]);
      for (int k = 0; k < N_ENT; k++) c3_r[k] <= c_r[k];
      // divider chain
      dv_r[0] <= d0;
      for (int s = 0; s < NUM_W; s++) dv_r[s+1] <= div_step(dv_r[s]);
      out_data_r <= res;
      out_sing_r <= dl.sing;
    end
  end

endmodule

FILE: sim/tb_matrix3x3_inverse_unit.sv
// self-checking testbench for the 3x3 matrix inverse pipeline
`timescale 1ns / 1ps

module tb_matrix3x3_inverse_unit;
  import m3inv_pkg::*;

  localparam int N_RAND = 1000;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_DIR = 14;

  typedef struct packed {
    logic [N_ENT-1:0][OUT_W-1:0] inv;
    logic                        sing;
  } inv_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [N_ENT*A_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [N_ENT*OUT_W-1:0] out_tdata;
  logic out_tuser;

  matrix3x3_inverse_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  inv_res_t expected_inv[$];
  int mismatches = 0;
  int n_checked = 0;
  int n_singular = 0;
  int idle_cnt = 0;
  bit calm = 1'b0;

  // exact adjugate over determinant, truncated toward zero, saturated
  function automatic inv_res_t compute_inverse(input logic [N_ENT*A_W-1:0] d);
    longint a[3][3];
    longint c[3][3];
    longint det, q, mx, mn;
    inv_res_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = longint'($signed(d[(i*3+j)*A_W +: A_W]));
    det = a[0][0]*a[1][1]*a[2][2] + a[0][1]*a[1][2]*a[2][0] + a[0][2]*a[1][0]*a[2][1]
        - a[0][2]*a[1][1]*a[2][0] - a[0][0]*a[1][2]*a[2][1] - a[0][1]*a[1][0]*a[2][2];
    c[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
    c[0][1] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
    c[0][2] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
    c[1][0] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
    c[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
    c[1][2] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
    c[2][0] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
    c[2][1] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
    c[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    mx = (longint'(1) <<< (OUT_W-1)) - 1;
    mn = -mx - 1;
    r = '0;
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        q = (c[j][i] * (longint'(1) <<< FRAC_BITS)) / det;
        if (q > mx) q = mx;
        if (q < mn) q = mn;
        r.inv[i*3+j] = q[OUT_W-1:0];
      end
    return r;
  endfunction

  function automatic logic [N_ENT*A_W-1:0] pack_m(input int e[9]);
    logic [N_ENT*A_W-1:0] d;
    for (int k = 0; k < 9; k++) d[k*A_W +: A_W] = e[k][A_W-1:0];
    return d;
  endfunction

  // receiver: random stall bursts, compare each result with the oldest prediction
  initial begin
    int stall;
    inv_res_t got, want;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.inv = out_tdata;
        got.sing = out_tuser;
        if (expected_inv.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h sing %b", got.inv, got.sing);
        end else begin
          want = expected_inv.pop_front();
          n_checked++;
          if (want.sing) n_singular++;
          if (got.sing !== want.sing) begin
            mismatches++;
            if (mismatches <= 10)
              $display("singular: expected %b got %b", want.sing, got.sing);
          end
          for (int k = 0; k < N_ENT; k++)
            if (got.inv[k] !== want.inv[k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("inv%0d%0d: expected %h got %h", k/3, k%3, want.inv[k], got.inv[k]);
            end
        end
      end
    end
  end

  // watchdog on cycles with no accepted request on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_matrix(input logic [N_ENT*A_W-1:0] d, input bit chk, input inv_res_t lit);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    expected_inv.push_back(chk ? lit : compute_inverse(d));
    @(posedge clk iff in_tready);
  endtask

  initial begin
    int e[9];
    int dir_m[N_DIR][9];
    bit dir_lit[N_DIR];
    inv_res_t lit, zero_sing, ident;
    logic [N_ENT*A_W-1:0] d;
    int kind;
    zero_sing = '0;
    zero_sing.sing = 1'b1;
    ident = '0;
    for (int k = 0; k < 9; k += 4) ident.inv[k] = OUT_W'(1 << FRAC_BITS);
    // directed table: identity, zero, extremes, rank-deficient, negative det
    dir_m = '{
      '{1,0,0, 0,1,0, 0,0,1},
      '{0,0,0, 0,0,0, 0,0,0},
      '{32767,32767,32767, 32767,32767,32767, 32767,32767,32767},
      '{-32768,0,0, 0,-32768,0, 0,0,-32768},
      '{32767,0,0, 0,32767,0, 0,0,32767},
      '{-32768,32767,-32768, 32767,-32768,32767, -32768,32767,32767},
      '{1,2,3, 2,4,6, 7,8,9},
      '{0,1,0, 1,0,0, 0,0,1},
      '{3,0,0, 0,7,0, 0,0,-1},
      '{1,1,0, 0,1,1, 1,0,1},
      '{-1,-1,-1, -1,-1,-1, -1,-1,-1},
      '{-32768,32767,0, 1,-1,32767, -32768,0,-32768},
      '{2,1,1, 1,2,1, 1,1,2},
      '{0,0,1, 0,1,0, 1,0,0}};
    dir_lit = '{1,1,1,0,0,0,1,0,0,0,1,0,0,0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < N_DIR; r++) begin
      lit = (r == 0) ? ident : zero_sing;
      send_matrix(pack_m(dir_m[r]), dir_lit[r], lit);
    end
    for (int n = 0; n < N_RAND; n++) begin
      if (n > N_RAND - 100) calm = 1'b1;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++)
        case (kind)
          0: e[k] = $urandom_range(0, 1) ? 32767 : -32768;
          1, 2: e[k] = int'($urandom_range(0, 14)) - 7;
          default: e[k] = int'($urandom_range(0, 65535)) - 32768;
        endcase
      // force a dependent row now and then
      if (kind == 3) for (int k = 0; k < 3; k++) e[6+k] = e[k];
      d = pack_m(e);
      send_matrix(d, 1'b0, zero_sing);
    end
    in_tvalid <= 1'b0;
    wait (expected_inv.size() == 0);
    repeat (60) @(posedge clk);
    $display("checked %0d inverses (%0d singular) from %0d directed and %0d random matrices",
             n_checked, n_singular, N_DIR, N_RAND);
    $display("mismatching fields: %0d", mismatches);
    if (mismatches == 0 && expected_inv.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/m3inv_pkg.sv
src/matrix3x3_inverse_unit.sv
sim/tb_matrix3x3_inverse_unit.sv
